// File: rtl/rsnh_pkg.sv
// shared types and constants of the ray-sphere nearest-hit core
`timescale 1ns / 1ps
`default_nettype none
package rsnh_pkg;

  // default table depth
  localparam int unsigned MAX_SPHERES_DEF = 64;

  // request kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RAY  = 1'b1;

  // sphere count register width (holds up to 127) and entry counter width (holds up to 2047)
  localparam int unsigned CNT_REG_W = 7;
  localparam int unsigned CW        = 11;

  // datapath widths
  localparam int unsigned TCA_W  = 36;  // signed projection length, Q20.16
  localparam int unsigned L2_W   = 66;  // squared distance to center, Q34.32
  localparam int unsigned R2_W   = 64;  // squared radius, Q32.32
  localparam int unsigned SQ_W   = 72;  // square root operand
  localparam int unsigned ROOT_W = SQ_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned T_W    = 37;  // unsaturated hit distance

  // stored sphere entry
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [R2_W-1:0]    r2;
  } entry_t;

  // per-entry control traveling along the pipeline
  typedef struct packed {
    logic vld;
    logic last;
    logic ok;
  } ctl_t;

  // square root cell payload
  typedef struct packed {
    ctl_t                      ctl;
    logic signed [TCA_W-1:0]   tca;
    logic [REM_W-1:0]          rem;
    logic [ROOT_W-1:0]         root;
    logic [SQ_W-1:0]           rest;
  } sq_t;

endpackage
`default_nettype wire

// File: rtl/rsnh_req_if.sv
// request channel: sphere loads and ray queries
`timescale 1ns / 1ps
`default_nettype none
interface rsnh_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [5:0]         slot;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic [30:0]        radius;

  modport source (output valid, kind, slot, point_x, point_y, point_z,
                  dir_x, dir_y, dir_z, radius, input ready);
  modport sink (input valid, kind, slot, point_x, point_y, point_z,
                dir_x, dir_y, dir_z, radius, output ready);
endinterface
`default_nettype wire

// File: rtl/rsnh_res_if.sv
// result channel: nearest hit of one ray
`timescale 1ns / 1ps
`default_nettype none
interface rsnh_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [5:0]         sphere_index;
  logic signed [31:0] distance;

  modport source (output valid, hit, sphere_index, distance, input ready);
  modport sink (input valid, hit, sphere_index, distance, output ready);
endinterface
`default_nettype wire

// File: rtl/rsnh_sqrt_cell.sv
// one cell of the square root chain: resolves one root bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module rsnh_sqrt_cell #(
  parameter int unsigned AW = 6
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  rsnh_pkg::sq_t       in_i,
  input  wire logic [AW-1:0]  idx_i,
  output rsnh_pkg::sq_t       out_o,
  output logic [AW-1:0]       idx_o
);

  logic [rsnh_pkg::REM_W-1:0] cur;
  logic [rsnh_pkg::REM_W-1:0] trial;
  logic                       ge;
  rsnh_pkg::sq_t              nxt_d;
  rsnh_pkg::sq_t              nxt_q;
  logic [AW-1:0]              idx_q;

  // bring down two operand bits, try root*4+1
  always_comb begin
    cur   = {in_i.rem[rsnh_pkg::REM_W-3:0], in_i.rest[rsnh_pkg::SQ_W-1 -: 2]};
    trial = {in_i.root, 2'b01};
    ge    = (cur >= trial);
    nxt_d      = in_i;
    nxt_d.rem  = ge ? (cur - trial) : cur;
    nxt_d.root = {in_i.root[rsnh_pkg::ROOT_W-2:0], ge};
    nxt_d.rest = in_i.rest << 2;
  end

  // hand over to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_q <= '0;
    end else begin
      nxt_q <= nxt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_i;
  end

  assign out_o = nxt_q;
  assign idx_o = idx_q;

endmodule
`default_nettype wire

// File: rtl/rsnh_geom.sv
// sphere table and front stages: offset, projection, squared lengths, radicand
`timescale 1ns / 1ps
`default_nettype none
module rsnh_geom #(
  parameter int unsigned MaxSpheres = rsnh_pkg::MAX_SPHERES_DEF,
  parameter int unsigned AW = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_en_i,
  input  wire logic [AW-1:0]      wr_addr_i,
  input  rsnh_pkg::entry_t        wr_entry_i,
  input  rsnh_pkg::ctl_t          rd_ctl_i,
  input  wire logic [AW-1:0]      rd_addr_i,
  input  wire logic signed [31:0] org_x_i,
  input  wire logic signed [31:0] org_y_i,
  input  wire logic signed [31:0] org_z_i,
  input  wire logic signed [31:0] dir_x_i,
  input  wire logic signed [31:0] dir_y_i,
  input  wire logic signed [31:0] dir_z_i,
  output rsnh_pkg::sq_t           out_o,
  output logic [AW-1:0]           idx_o
);

  localparam int unsigned TW = rsnh_pkg::TCA_W;

  rsnh_pkg::entry_t mem [MaxSpheres];
  rsnh_pkg::entry_t rd_q;

  rsnh_pkg::ctl_t c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic [AW-1:0]  i1_q, i2_q, i3_q, i4_q, i5_q, i6_q, i7_q;

  logic signed [32:0] lx_q, ly_q, lz_q;
  logic [rsnh_pkg::R2_W-1:0] r2_2q, r2_3q, r2_4q, r2_5q;
  logic signed [64:0] px_q, py_q, pz_q;
  logic [65:0]        sx_q, sy_q, sz_q;
  logic [32:0]        mx, my, mz;
  logic signed [TW-1:0] tca_4q, tca_5q, tca_6q;
  logic [rsnh_pkg::L2_W-1:0] l2_4q, l2_5q, l2_6q;
  logic [33:0] hh_q;
  logic [34:0] hl_q;
  logic [35:0] ll_q;
  logic [rsnh_pkg::SQ_W-1:0] lim_q;
  logic [rsnh_pkg::SQ_W:0]   diff;
  rsnh_pkg::sq_t out_q;

  // sphere table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
    rd_q <= mem[rd_addr_i];
    i1_q <= rd_addr_i;
  end

  // control of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else begin
      c1_q <= rd_ctl_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
      c5_q <= '{vld: c4_q.vld, last: c4_q.last, ok: c4_q.ok & ~tca_4q[TW-1]};
      c6_q <= c5_q;
    end
  end

  // magnitudes of the center offset and the radicand difference
  always_comb begin
    mx = lx_q[32] ? 33'(-lx_q) : 33'(lx_q);
    my = ly_q[32] ? 33'(-ly_q) : 33'(ly_q);
    mz = lz_q[32] ? 33'(-lz_q) : 33'(lz_q);
    diff = {1'b0, lim_q} - (rsnh_pkg::SQ_W + 1)'(l2_6q);
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    // offset from ray origin to center
    lx_q  <= 33'(rd_q.cx) - 33'(org_x_i);
    ly_q  <= 33'(rd_q.cy) - 33'(org_y_i);
    lz_q  <= 33'(rd_q.cz) - 33'(org_z_i);
    r2_2q <= rd_q.r2;
    i2_q  <= i1_q;
    // projections on the direction and squares of the offset
    px_q  <= 65'(lx_q) * 65'(dir_x_i);
    py_q  <= 65'(ly_q) * 65'(dir_y_i);
    pz_q  <= 65'(lz_q) * 65'(dir_z_i);
    sx_q  <= 66'(mx) * 66'(mx);
    sy_q  <= 66'(my) * 66'(my);
    sz_q  <= 66'(mz) * 66'(mz);
    r2_3q <= r2_2q;
    i3_q  <= i2_q;
    // tca with each term floored, squared length
    tca_4q <= TW'(px_q >>> 30) + TW'(py_q >>> 30) + TW'(pz_q >>> 30);
    l2_4q  <= sx_q + sy_q + sz_q;
    r2_4q  <= r2_3q;
    i4_q   <= i3_q;
    // partial products of tca squared
    hh_q   <= 34'(tca_4q[34:18]) * 34'(tca_4q[34:18]);
    hl_q   <= 35'(tca_4q[34:18]) * 35'(tca_4q[17:0]);
    ll_q   <= 36'(tca_4q[17:0]) * 36'(tca_4q[17:0]);
    tca_5q <= tca_4q;
    l2_5q  <= l2_4q;
    r2_5q  <= r2_4q;
    i5_q   <= i4_q;
    // tca squared plus radius squared
    lim_q  <= (rsnh_pkg::SQ_W'(hh_q) << 36) + (rsnh_pkg::SQ_W'(hl_q) << 19)
            + rsnh_pkg::SQ_W'(ll_q) + rsnh_pkg::SQ_W'(r2_5q);
    tca_6q <= tca_5q;
    l2_6q  <= l2_5q;
    i6_q   <= i5_q;
    i7_q   <= i6_q;
  end

  // radicand, reject when the ray misses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q.ctl  <= '{vld: c6_q.vld, last: c6_q.last, ok: c6_q.ok & ~diff[rsnh_pkg::SQ_W]};
      out_q.tca  <= tca_6q;
      out_q.rem  <= '0;
      out_q.root <= '0;
      out_q.rest <= diff[rsnh_pkg::SQ_W-1:0];
    end
  end

  assign out_o = out_q;
  assign idx_o = i7_q;

endmodule
`default_nettype wire

// File: rtl/ray_sphere_nearest_hit_core.sv
// top level: request control, sphere sweep, square root chain, nearest-hit tracking
//
//   channel  dir  handshake        payload
//   req_i    in   valid / ready    kind, slot, point_x/y/z, dir_x/y/z, radius
//   res_o    out  valid / ready    hit, sphere_index, distance
//   cfg      in   cfg_we_i         cfg_data_i = sphere_count
//
// a load is written into the table when it is taken; a ray is swept over n entries before the next request,
// n = min(sphere_count, MaxSpheres), or goes straight to the done state when n is zero, at one sphere
// a cycle through the table read port and the 36-cell root chain
// reset clears control and sphere_count; the table is undefined until loaded
// a finished result waits in the output register while the next request is taken;
// a second result waits in the done state until the first has been taken
`timescale 1ns / 1ps
`default_nettype none
module ray_sphere_nearest_hit_core #(
  parameter int unsigned MaxSpheres = rsnh_pkg::MAX_SPHERES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  rsnh_req_if.sink                               req_i,
  rsnh_res_if.source                             res_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [rsnh_pkg::CNT_REG_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = (MaxSpheres > 1) ? $clog2(MaxSpheres) : 1;
  localparam int unsigned CW = rsnh_pkg::CW;
  localparam int unsigned NCELL = rsnh_pkg::ROOT_W;
  localparam int unsigned TW = rsnh_pkg::T_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_d, state_q;
  logic [rsnh_pkg::CNT_REG_W-1:0] cnt_q;
  logic [CW-1:0] n_d, n_q, addr_q;
  logic signed [31:0] ox_q, oy_q, oz_q, dx_q, dy_q, dz_q;
  logic acc, acc_ray, acc_load, issue, issue_last;
  rsnh_pkg::entry_t wr_entry;
  rsnh_pkg::ctl_t   rd_ctl;

  rsnh_pkg::sq_t  chain [NCELL+1];
  logic [AW-1:0]  chain_idx [NCELL+1];

  rsnh_pkg::ctl_t         tk_q;
  logic [TW-1:0]          tk_t_q;
  logic [AW-1:0]          tk_idx_q;
  logic signed [TW:0]     tdiff;
  logic [TW-1:0]          tval;

  logic          found_q;
  logic [TW-1:0] best_t_q;
  logic [AW-1:0] best_idx_q;
  logic          out_free;

  logic               res_vld_q, res_hit_q;
  logic [5:0]         res_idx_q;
  logic signed [31:0] res_dist_q;

  // request handshake
  assign req_i.ready = (state_q == ST_IDLE);
  assign acc      = req_i.valid & req_i.ready;
  assign acc_ray  = acc & (req_i.kind == rsnh_pkg::KIND_RAY);
  assign acc_load = acc & (req_i.kind == rsnh_pkg::KIND_LOAD)
                  & ({5'd0, req_i.slot} < CW'(MaxSpheres));
  assign out_free = ~res_vld_q | res_o.ready;

  // number of entries to test
  assign n_d = ({4'd0, cnt_q} > CW'(MaxSpheres)) ? CW'(MaxSpheres) : {4'd0, cnt_q};

  // table write data, radius squared on the way in
  always_comb begin
    wr_entry.cx = req_i.point_x;
    wr_entry.cy = req_i.point_y;
    wr_entry.cz = req_i.point_z;
    wr_entry.r2 = rsnh_pkg::R2_W'(req_i.radius) * rsnh_pkg::R2_W'(req_i.radius);
  end

  // sweep issue
  assign issue      = (state_q == ST_SWEEP);
  assign issue_last = (addr_q == n_q - CW'(1));
  assign rd_ctl     = '{vld: issue, last: issue & issue_last, ok: issue};

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_ray) begin
          state_d = (n_d == '0) ? ST_DONE : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tk_q.vld && tk_q.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_data_i;
      end
      if (acc_ray) begin
        n_q    <= n_d;
        addr_q <= '0;
      end else if (issue) begin
        addr_q <= addr_q + CW'(1);
      end
    end
  end

  // ray held during the sweep
  always_ff @(posedge clk_i) begin
    if (acc_ray) begin
      ox_q <= req_i.point_x;
      oy_q <= req_i.point_y;
      oz_q <= req_i.point_z;
      dx_q <= req_i.dir_x;
      dy_q <= req_i.dir_y;
      dz_q <= req_i.dir_z;
    end
  end

  // table and front stages
  rsnh_geom #(
    .MaxSpheres (MaxSpheres),
    .AW         (AW)
  ) u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (acc_load),
    .wr_addr_i  (AW'(req_i.slot)),
    .wr_entry_i (wr_entry),
    .rd_ctl_i   (rd_ctl),
    .rd_addr_i  (addr_q[AW-1:0]),
    .org_x_i    (ox_q),
    .org_y_i    (oy_q),
    .org_z_i    (oz_q),
    .dir_x_i    (dx_q),
    .dir_y_i    (dy_q),
    .dir_z_i    (dz_q),
    .out_o      (chain[0]),
    .idx_o      (chain_idx[0])
  );

  // square root chain, one root bit per cell
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    rsnh_sqrt_cell #(
      .AW (AW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .in_i   (chain[g]),
      .idx_i  (chain_idx[g]),
      .out_o  (chain[g+1]),
      .idx_o  (chain_idx[g+1])
    );
  end

  // hit distance: near root, or far root when the origin is inside
  always_comb begin
    tdiff = (TW + 1)'(chain[NCELL].tca) - (TW + 1)'(chain[NCELL].root);
    tval  = tdiff[TW] ? (TW'(chain[NCELL].tca) + TW'(chain[NCELL].root)) : tdiff[TW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tk_q <= '0;
    end else begin
      tk_q <= chain[NCELL].ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    tk_t_q   <= tval;
    tk_idx_q <= chain_idx[NCELL];
  end

  // nearest hit so far, strict compare keeps the lower index on ties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      best_t_q   <= '0;
      best_idx_q <= '0;
    end else if (acc_ray) begin
      found_q    <= 1'b0;
      best_t_q   <= '0;
      best_idx_q <= '0;
    end else if (tk_q.vld && tk_q.ok && (!found_q || (tk_t_q < best_t_q))) begin
      found_q    <= 1'b1;
      best_t_q   <= tk_t_q;
      best_idx_q <= tk_idx_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q  <= 1'b0;
      res_hit_q  <= 1'b0;
      res_idx_q  <= '0;
      res_dist_q <= '0;
    end else if ((state_q == ST_DONE) && out_free) begin
      res_vld_q  <= 1'b1;
      res_hit_q  <= found_q;
      res_idx_q  <= 6'(best_idx_q);
      res_dist_q <= (best_t_q > TW'(32'h7fff_ffff)) ? 32'sh7fff_ffff
                                                    : 32'(best_t_q);
    end else if (res_o.ready) begin
      res_vld_q  <= 1'b0;
    end
  end

  assign res_o.valid        = res_vld_q;
  assign res_o.hit          = res_hit_q;
  assign res_o.sphere_index = res_idx_q;
  assign res_o.distance     = res_dist_q;

endmodule
`default_nettype wire

// File: rtl/rsnh_checker.sv
// port-level checks of the ray-sphere nearest-hit core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module rsnh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_hit,
  input wire logic [5:0]  out_index,
  input wire logic [31:0] out_distance
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_distance))
    else $error("stalled result changed");

  // a miss reports zero index and distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_hit |-> out_index == 6'd0 && out_distance == 32'd0)
    else $error("miss with nonzero fields");

  // distance is never negative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_hit |-> !out_distance[31])
    else $error("negative hit distance");

  // no new result in the cycle right after a request is taken while none is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early");

endmodule

bind ray_sphere_nearest_hit_core rsnh_checker u_rsnh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (req_i.valid),
  .in_ready     (req_i.ready),
  .out_valid    (res_o.valid),
  .out_ready    (res_o.ready),
  .out_hit      (res_o.hit),
  .out_index    (res_o.sphere_index),
  .out_distance (res_o.distance)
);
`default_nettype wire
